[hdl/rpd_pkg.sv]
package rpd_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 8;

  localparam int unsigned RegBits   = 20;
  localparam int unsigned SizeBits  = 13;
  localparam int unsigned RangeBits = 24;
  localparam int unsigned DepthBits = 26;
  localparam int unsigned OutCoordBits = 12;
  localparam int unsigned NormBits  = 24;
  localparam int unsigned SqBits    = 50;
  localparam int unsigned RootBits  = 25;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFocalX  = 3'd0,
    CfgFocalY  = 3'd1,
    CfgCenterX = 3'd2,
    CfgCenterY = 3'd3,
    CfgWidth   = 3'd4,
    CfgHeight  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [RegBits-1:0] focal_x;
    logic [RegBits-1:0] focal_y;
    logic [RegBits-1:0] center_x;
    logic [RegBits-1:0] center_y;
  } cam_cfg_t;

  typedef struct packed {
    logic [RangeBits-1:0]    range_cm;
    logic [OutCoordBits-1:0] col;
    logic [OutCoordBits-1:0] row;
    logic                    last;
  } pix_t;

endpackage

[hdl/range_to_planar_depth_top.sv]
// Range to planar depth conversion for a pinhole camera.
// Input channel: range_cm_i with in_valid/in_stall; a transfer happens at an
// edge where in_valid is high and in_stall low. Pixels arrive in raster order;
// internal column and row counters wrap at image_width, image_height or all-ones.
// Output channel: depth_m_o, pixel_col_o, pixel_row_o, frame_last_o with
// out_valid/out_stall. frame_last_o marks the last pixel of a frame.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while idle. cfg_ready is always high.
// A front stage counts coordinates and pushes pixels into a two-entry queue;
// the back stage works one pixel at a time through one shared restoring
// divider (64 and 65 steps for the two normalizing divisions, 65 for the depth
// division), a square stage and a 25-step square root, and takes a new pixel
// from the queue only after the output of the last one has been taken.
// Reset clears counters, the queue and the state, and sets the configuration
// registers to their defaults. While out_stall is high the result holds and the queue fills, then in_stall rises.
module range_to_planar_depth_top #(
  parameter int unsigned CoordBits = rpd_pkg::CoordBitsDef,
  parameter int unsigned FracBits  = rpd_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rpd_pkg::RangeBits-1:0]    range_cm_i,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rpd_pkg::DepthBits-1:0]    depth_m_o,
  output logic [rpd_pkg::OutCoordBits-1:0] pixel_col_o,
  output logic [rpd_pkg::OutCoordBits-1:0] pixel_row_o,
  output logic                             frame_last_o,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rpd_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  rpd_pkg::cam_cfg_t cam_q;
  logic [rpd_pkg::SizeBits-1:0] width_q, height_q;
  logic q_valid, q_ready;
  rpd_pkg::pix_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q.focal_x  <= 20'd131072;
      cam_q.focal_y  <= 20'd131072;
      cam_q.center_x <= 20'd81920;
      cam_q.center_y <= 20'd61440;
      width_q        <= 13'd640;
      height_q       <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpd_pkg::CfgFocalX:  cam_q.focal_x  <= cfg_data[rpd_pkg::RegBits-1:0];
        rpd_pkg::CfgFocalY:  cam_q.focal_y  <= cfg_data[rpd_pkg::RegBits-1:0];
        rpd_pkg::CfgCenterX: cam_q.center_x <= cfg_data[rpd_pkg::RegBits-1:0];
        rpd_pkg::CfgCenterY: cam_q.center_y <= cfg_data[rpd_pkg::RegBits-1:0];
        rpd_pkg::CfgWidth:   width_q        <= cfg_data[rpd_pkg::SizeBits-1:0];
        rpd_pkg::CfgHeight:  height_q       <= cfg_data[rpd_pkg::SizeBits-1:0];
        default: ;
      endcase
    end
  end

  rpd_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .range_cm_i,
    .width_i(width_q), .height_i(height_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  rpd_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .cfg_i(cam_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid, .out_stall, .depth_m_o, .pixel_col_o, .pixel_row_o, .frame_last_o
  );

endmodule

[hdl/rpd_front.sv]
module rpd_front #(
  parameter int unsigned CoordBits = rpd_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpd_pkg::RangeBits-1:0] range_cm_i,
  input  logic [rpd_pkg::SizeBits-1:0]  width_i,
  input  logic [rpd_pkg::SizeBits-1:0]  height_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output rpd_pkg::pix_t                 q_data_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned CmpBits = (CoordBits + 1 > rpd_pkg::SizeBits) ? CoordBits + 1
                                                                        : rpd_pkg::SizeBits;
  localparam logic [CoordBits-1:0] CoordMax = '1;

  logic [CoordBits-1:0] col_q, row_q;
  logic [CoordBits:0]   col_inc, row_inc;
  logic                 row_end, frame_end, push, pop;
  rpd_pkg::pix_t        mem_q [QDepth];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;

  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign row_end   = (CmpBits'(col_inc) >= CmpBits'(width_i)) || (col_q == CoordMax);
  assign frame_end = row_end &&
                     ((CmpBits'(row_inc) >= CmpBits'(height_i)) || (row_q == CoordMax));

  assign in_stall  = (cnt_q == 2'(QDepth));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
        if (row_end) begin
          col_q <= '0;
          row_q <= frame_end ? '0 : row_inc[CoordBits-1:0];
        end else begin
          col_q <= col_inc[CoordBits-1:0];
        end
      end
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].range_cm <= range_cm_i;
      mem_q[wr_q].col      <= rpd_pkg::OutCoordBits'(col_q);
      mem_q[wr_q].row      <= rpd_pkg::OutCoordBits'(row_q);
      mem_q[wr_q].last     <= frame_end;
    end
  end

endmodule

[hdl/rpd_back.sv]
module rpd_back #(
  parameter int unsigned FracBits = rpd_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rpd_pkg::cam_cfg_t               cfg_i,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  rpd_pkg::pix_t                   q_data_i,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rpd_pkg::DepthBits-1:0]   depth_m_o,
  output logic [rpd_pkg::OutCoordBits-1:0] pixel_col_o,
  output logic [rpd_pkg::OutCoordBits-1:0] pixel_row_o,
  output logic                            frame_last_o
);

  // Shared restoring divider: quotient bits, one per cycle.
  localparam int unsigned NumBits  = 64;
  localparam int unsigned DivBits  = 32;
  localparam int unsigned CntBits  = 7;
  localparam int unsigned SqrtSteps = 25;
  localparam logic [rpd_pkg::NormBits-1:0] NormMax = '1;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StDivA = 7'b0000010,
    StDivB = 7'b0000100,
    StSq   = 7'b0001000,
    StSqrt = 7'b0010000,
    StDepD = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q;
  rpd_pkg::pix_t pix_q;
  logic [CntBits-1:0]   cnt_q;
  logic [NumBits-1:0]   num_q;
  logic [DivBits+1:0]   rem_q;
  logic [DivBits-1:0]   den_q;
  logic [NumBits-1:0]   quo;
  logic [rpd_pkg::NormBits-1:0] a_q, b_q;
  logic [rpd_pkg::SqBits-1:0]   t_q;
  logic [rpd_pkg::SqBits-1:0]   sr_q;
  logic [rpd_pkg::DepthBits-1:0] depth_q;

  logic [DivBits+1:0] rem_sh, rem_sub;
  logic               fits;
  logic [rpd_pkg::RegBits+rpd_pkg::OutCoordBits:0] p, d;
  logic [rpd_pkg::RegBits-1:0] ctr, foc;
  logic [rpd_pkg::SqBits-1:0] sq_bit, sq_trial;
  logic [rpd_pkg::SqBits-1:0] sr_ext;
  logic [2*rpd_pkg::NormBits-1:0] aa, bb;

  assign rem_sh  = {rem_q[DivBits:0], num_q[NumBits-1]};
  assign rem_sub = rem_sh - {2'b0, den_q};
  assign fits    = !rem_sub[DivBits+1];
  assign quo     = {num_q[NumBits-2:0], fits};

  assign ctr = (state_q == StIdle) ? cfg_i.center_x : cfg_i.center_y;
  assign foc = (state_q == StIdle) ? cfg_i.focal_x  : cfg_i.focal_y;
  always_comb begin
    p = (state_q == StIdle)
        ? (($bits(p))'(q_data_i.col) << FracBits)
        : (($bits(p))'(pix_q.row) << FracBits);
    d = (p >= ($bits(p))'(ctr)) ? p - ($bits(p))'(ctr) : ($bits(p))'(ctr) - p;
  end

  assign sq_bit   = rpd_pkg::SqBits'(1) << (2 * (SqrtSteps - 1 - cnt_q));
  assign sr_ext   = sr_q;
  assign sq_trial = sr_ext + sq_bit;
  assign aa = a_q * a_q;
  assign bb = b_q * b_q;

  assign q_ready_o    = (state_q == StIdle);
  assign out_valid    = (state_q == StOut);
  assign depth_m_o    = depth_q;
  assign pixel_col_o  = pix_q.col;
  assign pixel_row_o  = pix_q.row;
  assign frame_last_o = pix_q.last;

  function automatic logic [rpd_pkg::NormBits-1:0] sat_norm(logic [NumBits-1:0] q);
    return (q > NumBits'(NormMax)) ? NormMax : q[rpd_pkg::NormBits-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: if (q_valid_i) begin
          state_q <= StDivA;
          cnt_q   <= '0;
        end
        StDivA: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(NumBits - 1)) begin
            state_q <= StDivB;
            cnt_q   <= '0;
          end
        end
        StDivB: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(NumBits)) begin
            state_q <= StSq;
            cnt_q   <= '0;
          end
        end
        StSq: begin
          state_q <= StSqrt;
          cnt_q   <= '0;
        end
        StSqrt: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(SqrtSteps - 1)) begin
            state_q <= StDepD;
            cnt_q   <= '0;
          end
        end
        StDepD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(NumBits)) state_q <= StOut;
        end
        StOut: if (!out_stall) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        pix_q <= q_data_i;
        num_q <= NumBits'(d) << 16;
        den_q <= DivBits'(foc);
        rem_q <= '0;
      end
      StDivA: begin
        num_q <= {num_q[NumBits-2:0], fits};
        rem_q <= fits ? rem_sub : rem_sh;
        if (cnt_q == CntBits'(NumBits - 1)) begin
          a_q   <= (den_q == '0) ? NormMax : sat_norm({num_q[NumBits-2:0], fits});
          num_q <= NumBits'(d) << 16;
          den_q <= DivBits'(foc);
          rem_q <= '0;
        end
      end
      StDivB: begin
        // first cycle loads row offset; d now uses row
        if (cnt_q == '0) begin
          num_q <= NumBits'(d) << 16;
          den_q <= DivBits'(foc);
          rem_q <= '0;
        end else begin
          num_q <= {num_q[NumBits-2:0], fits};
          rem_q <= fits ? rem_sub : rem_sh;
          if (cnt_q == CntBits'(NumBits))
            b_q <= (den_q == '0) ? NormMax : sat_norm({num_q[NumBits-2:0], fits});
        end
      end
      StSq: begin
        t_q  <= rpd_pkg::SqBits'(aa) + rpd_pkg::SqBits'(bb) + (rpd_pkg::SqBits'(1) << 32);
        sr_q <= '0;
      end
      StSqrt: begin
        // sr holds partial root shifted; restoring bit-pair method
        if (t_q >= sq_trial) begin
          t_q  <= t_q - sq_trial;
          sr_q <= (sr_ext >> 1) + sq_bit;
        end else begin
          sr_q <= sr_ext >> 1;
        end
        if (cnt_q == CntBits'(SqrtSteps - 1)) begin
          num_q <= NumBits'(pix_q.range_cm) << (32 - FracBits);
          rem_q <= '0;
        end
      end
      StDepD: begin
        if (cnt_q == '0) begin
          den_q <= DivBits'(sr_q[rpd_pkg::RootBits:0]) * DivBits'(100);
        end else begin
          num_q <= {num_q[NumBits-2:0], fits};
          rem_q <= fits ? rem_sub : rem_sh;
          if (cnt_q == CntBits'(NumBits)) begin
            depth_q <= (quo > NumBits'({rpd_pkg::DepthBits{1'b1}}))
                       ? '1 : quo[rpd_pkg::DepthBits-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[tb/sv/depth_checker.sv]
module depth_checker
  import rpd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [RangeBits-1:0]    range_cm_i,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [DepthBits-1:0]    depth_m_o,
  input  logic [OutCoordBits-1:0] pixel_col_o,
  input  logic [OutCoordBits-1:0] pixel_row_o,
  input  logic                    frame_last_o,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CfgIdxBits-1:0]   cfg_index,
  input  logic [31:0]             cfg_data,
  output int                      fail_count,
  output int                      pending
);

  localparam int unsigned CoordBits = CoordBitsDef;
  localparam int unsigned FracBits  = FracBitsDef;
  localparam longint unsigned CoordMax = (64'd1 << CoordBits) - 1;
  localparam longint unsigned NormMax  = (64'd1 << NormBits) - 1;
  localparam longint unsigned DepthMax = (64'd1 << DepthBits) - 1;

  typedef struct {
    logic [DepthBits-1:0]    depth;
    logic [OutCoordBits-1:0] col;
    logic [OutCoordBits-1:0] row;
    logic                    last;
  } depth_pix_t;

  cam_cfg_t            cam;
  logic [SizeBits-1:0] img_w;
  logic [SizeBits-1:0] img_h;
  longint unsigned     col_pos;
  longint unsigned     row_pos;
  depth_pix_t          depth_queue[$];

  initial begin
    fail_count = 0;
    cam.focal_x  = 20'd131072;
    cam.focal_y  = 20'd131072;
    cam.center_x = 20'd81920;
    cam.center_y = 20'd61440;
    img_w   = 13'd640;
    img_h   = 13'd480;
    col_pos = 0;
    row_pos = 0;
  end

  assign pending = depth_queue.size();

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // |pos - center| / focal in Q8.16, saturated
  function automatic longint unsigned ray_offset(longint unsigned pos, longint unsigned ctr,
                                                 longint unsigned focal);
    longint unsigned p;
    longint unsigned d;
    longint unsigned q;
    p = pos << FracBits;
    d = (p >= ctr) ? p - ctr : ctr - p;
    if (focal == 0) return NormMax;
    q = (d << 16) / focal;
    return (q > NormMax) ? NormMax : q;
  endfunction

  function automatic depth_pix_t planar_depth_of(longint unsigned rng);
    depth_pix_t      px;
    longint unsigned a;
    longint unsigned b;
    longint unsigned s;
    longint unsigned dep;
    bit              row_end;
    bit              frame_end;
    a = ray_offset(col_pos, cam.center_x, cam.focal_x);
    b = ray_offset(row_pos, cam.center_y, cam.focal_y);
    s = root_floor(a * a + b * b + (64'd1 << 32));
    dep = (rng << (32 - FracBits)) / (100 * s);
    if (dep > DepthMax) dep = DepthMax;
    row_end   = (col_pos + 1 >= img_w) || (col_pos == CoordMax);
    frame_end = row_end && ((row_pos + 1 >= img_h) || (row_pos == CoordMax));
    px.depth = dep[DepthBits-1:0];
    px.col   = col_pos[OutCoordBits-1:0];
    px.row   = row_pos[OutCoordBits-1:0];
    px.last  = frame_end;
    // advance the raster position
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : ((row_pos + 1) & CoordMax);
    end else begin
      col_pos = (col_pos + 1) & CoordMax;
    end
    return px;
  endfunction

  task automatic report(string what, longint unsigned want, longint unsigned got);
    $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    depth_pix_t want;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgFocalX:  cam.focal_x  = cfg_data[RegBits-1:0];
        CfgFocalY:  cam.focal_y  = cfg_data[RegBits-1:0];
        CfgCenterX: cam.center_x = cfg_data[RegBits-1:0];
        CfgCenterY: cam.center_y = cfg_data[RegBits-1:0];
        CfgWidth:   img_w = cfg_data[SizeBits-1:0];
        CfgHeight:  img_h = cfg_data[SizeBits-1:0];
        default: ;
      endcase
    end
    if (in_valid && !in_stall) depth_queue.push_back(planar_depth_of(range_cm_i));
    if (out_valid && !out_stall) begin
      if (depth_queue.size() == 0) begin
        report("unexpected transfer, depth", 0, depth_m_o);
      end else begin
        want = depth_queue.pop_front();
        if (depth_m_o !== want.depth) report("depth_m", want.depth, depth_m_o);
        if (pixel_col_o !== want.col) report("pixel_col", want.col, pixel_col_o);
        if (pixel_row_o !== want.row) report("pixel_row", want.row, pixel_row_o);
        if (frame_last_o !== want.last) report("frame_last", want.last, frame_last_o);
      end
    end
  end

endmodule

[tb/sv/tb.sv]
module tb;
  import rpd_pkg::*;

  localparam logic [CfgIdxBits-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgSpareHi = 3'd7;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RangeBits-1:0]    range_cm_i = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DepthBits-1:0]    depth_m_o;
  logic [OutCoordBits-1:0] pixel_col_o;
  logic [OutCoordBits-1:0] pixel_row_o;
  logic                    frame_last_o;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxBits-1:0]   cfg_index = '0;
  logic [31:0]             cfg_data = '0;

  int fail_count;
  int pending;
  int send_gap_pct = 25;
  int recv_stall_pct = 52;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  always #4 clk_i = ~clk_i;

  range_to_planar_depth_top dut (.*);

  depth_checker chk (.*);

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    int held;
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      held++;
      if (held >= 800) hold_done = 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] w, logic [31:0] h);
    cfg_write(CfgFocalX, fx);
    cfg_write(CfgFocalY, fy);
    cfg_write(CfgCenterX, cx);
    cfg_write(CfgCenterY, cy);
    cfg_write(CfgWidth, w);
    cfg_write(CfgHeight, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_range(logic [RangeBits-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    range_cm_i <= val;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid, drain, then let the back stage settle before the next write
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic logic [RangeBits-1:0] rand_range;
    case ($urandom_range(3))
      0: return RangeBits'($urandom_range(255));
      1: return '1;
      default: return RangeBits'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_focal;
    case ($urandom_range(4))
      0: return $urandom_range(1, 255);
      1: return $urandom;
      default: return $urandom_range(256, 262144);
    endcase
  endfunction

  function automatic logic [31:0] rand_size;
    case ($urandom_range(9))
      0: return $urandom;
      1: return 4096;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int burst;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // small raster at default optics: both range extremes and a frame end
    configure(131072, 131072, 81920, 61440, 3, 2);
    send_range('0);
    send_range('1);
    send_range(24'h000001);
    send_range(24'h800000);
    send_range(24'h7FFFFF);
    send_range(24'h0000FF);
    drain();

    // unused indices are ignored; zero focal length and near-zero focal
    // (steep ray); zero sizes act as one
    cfg_write(CfgSpareLo, 32'hFFFF_FFFF);
    cfg_write(CfgSpareHi, 32'h0000_0000);
    configure(0, 1, 0, 20'hFFFFF, 0, 0);
    send_range('1);
    send_range('0);
    send_range(24'h123456);
    drain();

    // extreme registers, upper data bits must be masked away
    configure(32'hFFFF_FFFF, 32'hFFF0_0001, 32'hFFFF_FFFF, 32'h0, 32'hFFF0_1000,
              32'h0000_1000);
    send_range('1);
    send_range(24'hAAAAAA);
    send_range(24'h555555);
    drain();
    configure(20'hFFFFF, 20'hFFFFF, 0, 0, 8191, 8191);
    send_range('1);
    send_range(24'h000100);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 5) begin
        send_gap_pct = 25;
        recv_stall_pct = 52;
      end else if (ph < 10) begin
        send_gap_pct = 52;
        recv_stall_pct = 25;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      configure(rand_focal(), rand_focal(), $urandom_range(0, 4096),
                $urandom_range(0, 4096), rand_size(), rand_size());
      if (ph == 2) hold_go = 1'b1;
      burst = 40;
      for (int k = 0; k < burst; k++) send_range(rand_range());
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
